FILE: rtl/m3i_pkg.sv
// shared widths, types and constants of the 3x3 matrix inverse
// no dependencies; imported by every module of the block
`default_nettype none
package m3i_pkg;

   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_W     = 31;
   localparam int NUM_ELEM  = 9;

   // payload widths, packed and padded to whole bytes
   localparam int ELEMS_W = NUM_ELEM * ELEM_W;
   localparam int DATA_W  = ((ELEMS_W + 7) / 8) * 8;

   // exact intermediate widths
   localparam int PROD_W = 2 * ELEM_W;
   localparam int COF_W  = 2 * ELEM_W + 1;
   localparam int CMAG_W = 2 * ELEM_W;
   localparam int PP_W   = 2 * ELEM_W + 1;
   localparam int DET_W  = 3 * ELEM_W + 2;
   localparam int DMAG_W = DET_W - 1;

   // threshold compare width
   localparam int LIM_W = THR_W + 2 * FRAC_BITS;
   localparam int CMP_W = (LIM_W > DMAG_W) ? LIM_W : DMAG_W;

   // divider widths: numerator, denominator, partial remainder
   localparam int SH_W  = CMAG_W + 2 * FRAC_BITS + 1;
   localparam int NUM_W = ((SH_W > DMAG_W) ? SH_W : DMAG_W) + 1;
   localparam int DEN_W = DMAG_W + 1;
   localparam int REM_W = ((NUM_W > DEN_W + ELEM_W) ? NUM_W : DEN_W + ELEM_W) + 1;

   // determinant side data shared by all lanes
   typedef struct packed {
      logic              vld;
      logic              sng;
      logic              dneg;
      logic [DMAG_W-1:0] dmag;
   } det_info_type;

   // one lane's finished quotient
   typedef struct packed {
      logic              vld;
      logic              sng;
      logic [ELEM_W-1:0] q;
   } lane_out_type;

endpackage
`default_nettype wire

FILE: rtl/m3i_front.sv
// cofactor and determinant pipeline: products, cofactors, det, magnitude, singular test
// depends on m3i_pkg
`default_nettype none
module m3i_front import m3i_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_vld,
   input  logic signed [ELEM_W-1:0] elem [NUM_ELEM],
   input  logic [THR_W-1:0]         thr,
   output det_info_type             info,
   output logic signed [COF_W-1:0]  cof [NUM_ELEM]
);

   // operand pairs: cofactor i = elem[a]*elem[b] - elem[c]*elem[d]
   localparam int IDX [36] = '{4, 8, 7, 5,  2, 7, 1, 8,  1, 5, 2, 4,
                               5, 6, 3, 8,  0, 8, 2, 6,  3, 2, 0, 5,
                               3, 7, 6, 4,  6, 1, 0, 7,  0, 4, 3, 1};
   // cofactors that pair with row 0
   localparam int DIDX [3] = '{0, 3, 6};

   logic                     s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic signed [PROD_W-1:0] prod_ff [18];
   logic signed [ELEM_W-1:0] row1_ff [3];
   logic signed [ELEM_W-1:0] row2_ff [3];
   logic signed [COF_W-1:0]  cof2_ff [NUM_ELEM];
   logic signed [COF_W-1:0]  cof3_ff [NUM_ELEM];
   logic signed [COF_W-1:0]  cof4_ff [NUM_ELEM];
   logic signed [COF_W-1:0]  cof5_ff [NUM_ELEM];
   logic signed [PP_W-1:0]   pplo_ff [3];
   logic signed [PP_W-1:0]   pphi_ff [3];
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DET_W-1:0]  det_in;
   det_info_type             info_ff, info_in;
   logic [DET_W-1:0]         dabs;
   logic [CMP_W-1:0]         lim;

   // stage 1: eighteen element products, with row 0 registered alongside
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 18; j++) begin
            prod_ff[j] <= PROD_W'(elem[IDX[2*j]]) * PROD_W'(elem[IDX[2*j+1]]);
         end
         for (int j = 0; j < 3; j++) begin
            row1_ff[j] <= elem[j];
         end
      end
   end

   // stage 2: cofactor differences
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_ELEM; i++) begin
            cof2_ff[i] <= COF_W'(prod_ff[2*i]) - COF_W'(prod_ff[2*i+1]);
         end
         row2_ff <= row1_ff;
      end
   end

   // stage 3: row 0 times cofactor, split into two partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < 3; t++) begin
            pplo_ff[t] <= PP_W'(row2_ff[t]) *
                          PP_W'($signed({1'b0, cof2_ff[DIDX[t]][ELEM_W-1:0]}));
            pphi_ff[t] <= PP_W'(row2_ff[t]) *
                          PP_W'($signed(cof2_ff[DIDX[t]][COF_W-1:ELEM_W]));
         end
         cof3_ff <= cof2_ff;
      end
   end

   // stage 4: determinant sum
   always_comb begin
      det_in = '0;
      for (int t = 0; t < 3; t++) begin
         det_in = det_in + (DET_W'(pphi_ff[t]) <<< ELEM_W) + DET_W'(pplo_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= det_in;
         cof4_ff <= cof3_ff;
      end
   end

   // stage 5: magnitude, sign and singular test
   assign dabs = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
   assign lim  = CMP_W'({thr, {(2*FRAC_BITS){1'b0}}});

   always_comb begin
      info_in.vld  = s4_vld_ff;
      info_in.dneg = det_ff[DET_W-1];
      info_in.dmag = dabs[DMAG_W-1:0];
      info_in.sng  = CMP_W'(dabs[DMAG_W-1:0]) <= lim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff.vld <= 1'b0;
      end else if (en) begin
         info_ff.vld <= info_in.vld;
      end
      if (en) begin
         info_ff.sng  <= info_in.sng;
         info_ff.dneg <= info_in.dneg;
         info_ff.dmag <= info_in.dmag;
         cof5_ff      <= cof4_ff;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         s4_vld_ff   <= 1'b0;
      end else if (en) begin
         s1_vld_ff   <= in_vld;
         s2_vld_ff   <= s1_vld_ff;
         s3_vld_ff   <= s2_vld_ff;
         s4_vld_ff   <= s3_vld_ff;
      end
   end

   assign info = info_ff;
   assign cof  = cof5_ff;

endmodule
`default_nettype wire

FILE: rtl/m3i_lane.sv
// one division lane: rounded cofactor / determinant, one quotient bit per stage, saturated
// depends on m3i_pkg
`default_nettype none
module m3i_lane import m3i_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  det_info_type            info,
   input  logic signed [COF_W-1:0] cof,
   output lane_out_type            result
);

   logic              a_vld_ff, a_sng_ff, a_neg_ff;
   logic [NUM_W-1:0]  a_num_ff;
   logic [DEN_W-1:0]  a_den_ff;
   logic [CMAG_W-1:0] cmag;
   logic [COF_W-1:0]  cabs;
   logic [REM_W-1:0]  den_top;

   logic              vld_ff [ELEM_W+1];
   logic              sng_ff [ELEM_W+1];
   logic              neg_ff [ELEM_W+1];
   logic              ovf_ff [ELEM_W+1];
   logic [DEN_W-1:0]  den_ff [ELEM_W+1];
   logic [REM_W-1:0]  rem_ff [ELEM_W+1];
   logic [ELEM_W-1:0] quo_ff [ELEM_W+1];

   lane_out_type      result_ff, result_in;
   logic [ELEM_W-1:0] sat_lim, sat_q;

   // stage a: magnitudes, rounding numerator and doubled divisor
   assign cabs = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
   assign cmag = cabs[CMAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= info.vld;
      end
      if (en) begin
         a_sng_ff <= info.sng;
         a_neg_ff <= cof[COF_W-1] ^ info.dneg;
         a_num_ff <= (NUM_W'(cmag) << (2 * FRAC_BITS + 1)) + NUM_W'(info.dmag);
         a_den_ff <= {info.dmag, 1'b0};
      end
   end

   // stage b: overflow check against the full quotient range
   assign den_top = REM_W'(a_den_ff) << ELEM_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= a_vld_ff;
      end
      if (en) begin
         sng_ff[0] <= a_sng_ff;
         neg_ff[0] <= a_neg_ff;
         ovf_ff[0] <= REM_W'(a_num_ff) >= den_top;
         den_ff[0] <= a_den_ff;
         rem_ff[0] <= REM_W'(a_num_ff);
         quo_ff[0] <= '0;
      end
   end

   // restoring division, most significant quotient bit first
   for (genvar s = 0; s < ELEM_W; s++) begin : g_div
      localparam int K = ELEM_W - 1 - s;
      logic [REM_W-1:0]  dk;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ELEM_W-1:0] quo_in;

      assign dk     = REM_W'(den_ff[s]) << K;
      assign ge     = rem_ff[s] >= dk;
      assign rem_in = ge ? rem_ff[s] - dk : rem_ff[s];
      assign quo_in = quo_ff[s] | (ELEM_W'(ge) << K);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (en) begin
            sng_ff[s+1] <= sng_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            den_ff[s+1] <= den_ff[s];
            rem_ff[s+1] <= rem_in;
            quo_ff[s+1] <= quo_in;
         end
      end
   end

   // saturate and apply the sign
   assign sat_lim = neg_ff[ELEM_W] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
   assign sat_q   = (ovf_ff[ELEM_W] || (quo_ff[ELEM_W] > sat_lim)) ? sat_lim : quo_ff[ELEM_W];

   always_comb begin
      result_in.vld = vld_ff[ELEM_W];
      result_in.sng = sng_ff[ELEM_W];
      result_in.q   = neg_ff[ELEM_W] ? ELEM_W'(-sat_q) : sat_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff.vld <= 1'b0;
      end else if (en) begin
         result_ff.vld <= result_in.vld;
      end
      if (en) begin
         result_ff.sng <= result_in.sng;
         result_ff.q   <= result_in.q;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

FILE: rtl/m3i_merge.sv
// merge stage: gathers the nine lane quotients, zeroes them for a singular matrix
// depends on m3i_pkg
`default_nettype none
module m3i_merge import m3i_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  lane_out_type       lanes [NUM_ELEM],
   output logic               tail_vld,
   output logic               tail_sng,
   output logic [ELEMS_W-1:0] tail_data
);

   logic               vld_ff, sng_ff;
   logic [ELEMS_W-1:0] data_ff, data_in;

   // pack lanes in row-major order, lowest element first
   always_comb begin
      data_in = '0;
      for (int i = 0; i < NUM_ELEM; i++) begin
         data_in[i*ELEM_W +: ELEM_W] = lanes[0].sng ? '0 : lanes[i].q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= lanes[0].vld;
      end
      if (en) begin
         sng_ff  <= lanes[0].sng;
         data_ff <= data_in;
      end
   end

   assign tail_vld  = vld_ff;
   assign tail_sng  = sng_ff;
   assign tail_data = data_ff;

endmodule
`default_nettype wire

FILE: rtl/matrix3_inverse.sv
// matrix3_inverse: 3x3 signed fixed-point inverse by adjugate over determinant
// top level; depends on m3i_pkg, m3i_front, m3i_lane and m3i_merge
//
// usage:
//   req_* carries one request, a row-major 3x3 matrix of signed Q16.16 elements.
//   rsp_* returns one result per request: the nine inverse elements, each rounded
//   to nearest (ties away from zero) and saturated, plus a singular flag in tuser.
//   csr_we/csr_wdata write the zero threshold (unsigned Q15.16 magnitude, reset value one LSB);
//   a determinant magnitude at or below it flags the matrix singular and zeroes the data.
// pipeline: 5 cofactor and determinant stages, 2 divider setup stages, 32
//   quotient-bit stages in each of the nine division lanes, one saturation stage
//   and one merge stage.
// throughput: one request per cycle while the skid register is empty; the 32-stage
//   divider lanes are fully pipelined.
// reset: synchronous, clears all valid bits and the skid stage and loads the
//   threshold with 1.
// stall: when rsp_tready is low the pending result moves into a skid register
//   and req_tready drops the next cycle; the whole pipeline then holds until
//   the skid register is drained.
`default_nettype none
module matrix3_inverse import m3i_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request: m00 m01 m02 m10 m11 m12 m20 m21 m22, 32 bits each from the lowest bit
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   // result: inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22 from the lowest bit
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   // result: singular
   output logic              rsp_tuser,
   input  logic              csr_we,
   input  logic [THR_W-1:0]  csr_wdata
);

   logic [THR_W-1:0]         thr_ff;
   logic                     en;
   logic signed [ELEM_W-1:0] elem [NUM_ELEM];
   det_info_type             info;
   logic signed [COF_W-1:0]  cof [NUM_ELEM];
   lane_out_type             lanes [NUM_ELEM];
   logic                     tail_vld, tail_sng;
   logic [ELEMS_W-1:0]       tail_data;
   logic                     skid_vld_ff, skid_vld_in, skid_sng_ff;
   logic [ELEMS_W-1:0]       skid_data_ff;
   logic [ELEMS_W-1:0]       out_data;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // pipeline advances whenever the skid register is free
   assign en         = !skid_vld_ff;
   assign req_tready = en;

   // unpack request elements
   always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         elem[i] = $signed(req_tdata[i*ELEM_W +: ELEM_W]);
      end
   end

   m3i_front u_front (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .in_vld (req_tvalid),
      .elem   (elem),
      .thr    (thr_ff),
      .info   (info),
      .cof    (cof)
   );

   // nine division lanes, one per cofactor
   for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
      m3i_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .info   (info),
         .cof    (cof[i]),
         .result (lanes[i])
      );
   end

   m3i_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .lanes     (lanes),
      .tail_vld  (tail_vld),
      .tail_sng  (tail_sng),
      .tail_data (tail_data)
   );

   // skid register catches the tail result when the receiver stalls
   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff && rsp_tready) begin
         skid_vld_in = 1'b0;
      end else if (!skid_vld_ff && tail_vld && !rsp_tready) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
      if (!skid_vld_ff) begin
         skid_sng_ff  <= tail_sng;
         skid_data_ff <= tail_data;
      end
   end

   // result select
   assign out_data   = skid_vld_ff ? skid_data_ff : tail_data;
   assign rsp_tvalid = skid_vld_ff || tail_vld;
   assign rsp_tuser  = skid_vld_ff ? skid_sng_ff : tail_sng;
   assign rsp_tdata  = DATA_W'(out_data);

   // a singular result carries all-zero data
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("singular result with nonzero data");

   // first and last lanes stay in step; the flag only matters on a valid lane result
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lanes[0].vld == lanes[NUM_ELEM-1].vld &&
      (!lanes[0].vld || lanes[0].sng == lanes[NUM_ELEM-1].sng))
      else $error("division lanes out of step");

   // skid fills only from a stalled tail result
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      !skid_vld_ff ##1 skid_vld_ff |-> $past(tail_vld && !rsp_tready))
      else $error("skid register loaded without a stall");

endmodule
`default_nettype wire

FILE: dv/matrix3_inverse_tb.sv
// testbench for matrix3_inverse: streams random and directed 3x3 matrices
// depends on m3i_pkg and the matrix3_inverse rtl; checks every result exactly
`timescale 1ns / 1ps
module matrix3_inverse_tb;
   import m3i_pkg::*;

   typedef bit signed [127:0] wide_type;

   typedef struct packed {
      bit [DATA_W-1:0] data;
      bit              singular;
   } inverse_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 50;

   // scoreboard: predicts each inverse and checks results in order
   class inverse_scoreboard;
      inverse_type pending[$];
      bit [30:0]   threshold;
      int          errors;
      int          checked;
      int          singular_seen;

      function new();
         threshold = 31'd1;
         errors = 0;
         checked = 0;
         singular_seen = 0;
      endfunction

      // one element: cofactor over determinant, rounded and saturated
      function bit [31:0] divide_round(wide_type cofv, wide_type detv);
         bit          neg;
         bit [255:0]  ac;
         bit [255:0]  ad;
         bit [255:0]  q;
         bit [255:0]  lim;
         neg = (cofv < 0) != (detv < 0);
         ac = (cofv < 0) ? 256'(-cofv) : 256'(cofv);
         ad = (detv < 0) ? 256'(-detv) : 256'(detv);
         q = ((ac << (2 * FRAC_BITS + 1)) + ad) / (ad << 1);
         lim = neg ? (256'd1 << 31) : ((256'd1 << 31) - 1);
         if (q > lim) q = lim;
         return neg ? -q[31:0] : q[31:0];
      endfunction

      function void note_request(bit [DATA_W-1:0] d);
         wide_type    m[9];
         wide_type    c[9];
         wide_type    detv;
         bit [127:0]  mag;
         inverse_type exp_res;
         for (int i = 0; i < 9; i++) m[i] = wide_type'($signed(d[32*i +: 32]));
         c[0] = m[4]*m[8] - m[7]*m[5];
         c[1] = m[2]*m[7] - m[1]*m[8];
         c[2] = m[1]*m[5] - m[2]*m[4];
         c[3] = m[5]*m[6] - m[3]*m[8];
         c[4] = m[0]*m[8] - m[2]*m[6];
         c[5] = m[3]*m[2] - m[0]*m[5];
         c[6] = m[3]*m[7] - m[6]*m[4];
         c[7] = m[6]*m[1] - m[0]*m[7];
         c[8] = m[0]*m[4] - m[3]*m[1];
         detv = m[0]*c[0] + m[1]*c[3] + m[2]*c[6];
         mag = (detv < 0) ? 128'(-detv) : 128'(detv);
         exp_res = '0;
         if (mag <= (128'(threshold) << (2 * FRAC_BITS))) begin
            exp_res.singular = 1'b1;
         end else begin
            for (int i = 0; i < 9; i++) exp_res.data[32*i +: 32] = divide_round(c[i], detv);
         end
         pending.push_back(exp_res);
      endfunction

      function void check_result(bit [DATA_W-1:0] d, bit sng);
         inverse_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h singular=%b", $time, d, sng);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (sng) singular_seen++;
         if (e.singular !== sng) begin
            $display("%0t: singular mismatch expected %b actual %b", $time, e.singular, sng);
            errors++;
         end
         for (int i = 0; i < 9; i++) begin
            if (e.data[32*i +: 32] !== d[32*i +: 32]) begin
               $display("%0t: inv%0d%0d mismatch expected %h actual %h", $time, i / 3, i % 3,
                        e.data[32*i +: 32], d[32*i +: 32]);
               errors++;
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              csr_we;
   logic [THR_W-1:0]  csr_wdata;

   inverse_scoreboard board;
   int unsigned       cycles;
   int unsigned       sent;

   matrix3_inverse dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("matrix3_inverse regression: fail");
         $finish;
      end
   end

   // send one request after a random gap
   task automatic send_matrix(bit [DATA_W-1:0] d);
      int gap;
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      board.note_request(d);
      sent++;
   endtask

   // wait for the pipeline to drain, then write the threshold
   task automatic set_threshold(bit [30:0] v);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.threshold = v;
   endtask

   function automatic bit [DATA_W-1:0] build(bit [31:0] a0, bit [31:0] a1, bit [31:0] a2,
                                             bit [31:0] a3, bit [31:0] a4, bit [31:0] a5,
                                             bit [31:0] a6, bit [31:0] a7, bit [31:0] a8);
      return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
   endfunction

   // random matrix: full range, small q values or nearly dependent rows
   function automatic bit [DATA_W-1:0] random_matrix();
      bit [DATA_W-1:0] d;
      int              kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         if (kind < 3) d[32*i +: 32] = $urandom;
         else d[32*i +: 32] = 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
      end
      if (kind >= 8) begin
         for (int i = 0; i < 3; i++)
            d[32*(6+i) +: 32] = d[32*i +: 32] + 32'($urandom_range(0, 8)) - 32'd4;
      end
      return d;
   endfunction

   // result side: random stalls, check every accepted result
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata, rsp_tuser);
         gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // main sequence
   initial begin
      localparam bit [31:0] ONE  = 32'h0001_0000;
      localparam bit [31:0] MAXV = 32'h7FFF_FFFF;
      localparam bit [31:0] MINV = 32'h8000_0000;
      board = new();
      sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, zero, extremes, scaling, saturation
      send_matrix(build(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix('0);
      send_matrix(build(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      send_matrix(build(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
      send_matrix(build(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
      send_matrix(build(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
      send_matrix(build(MINV, MAXV, 0, 0, MINV, MAXV, MAXV, 0, MINV));
      send_matrix(build(2*ONE, ONE, 0, ONE, 2*ONE, ONE, 0, ONE, 2*ONE));
      send_matrix(build(-ONE, 0, 0, 0, ONE, 0, 0, 0, 3*ONE));
      // rounding: fractions 1/3, -1/3 and 1/2
      send_matrix(build(3*ONE, 0, 0, 0, -3*ONE, 0, 0, 0, 32'h0002_0000));
      // det exactly at threshold one, then just above
      send_matrix(build(1, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(build(2, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(build(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(build(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE));

      // threshold zero: only an exact zero determinant is singular
      set_threshold(31'd0);
      send_matrix(build(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(build(-1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(build(1, MAXV, 0, 0, 1, 0, MINV, 0, 1));
      send_matrix(build(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE));
      send_matrix(build(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV));

      // random phases over several thresholds
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_threshold(31'd1);
            1: set_threshold(31'h7FFF_FFFF);
            2: set_threshold(31'h0001_0000);
            3: set_threshold(31'd0);
            4: set_threshold(31'($urandom));
            default: set_threshold(31'($urandom_range(0, 255)));
         endcase
         for (int k = 0; k < 150; k++) send_matrix(random_matrix());
      end

      // drain and finish
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d matrices over 8 threshold settings, checked %0d results (%0d singular)",
               sent, board.checked, board.singular_seen);
      if (board.errors == 0 && board.checked == sent) begin
         $display("matrix3_inverse regression: pass");
      end else begin
         $display("matrix3_inverse regression: fail");
      end
      $finish;
   end

endmodule

FILE: matrix3_inverse.f
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_lane.sv
rtl/m3i_merge.sv
rtl/matrix3_inverse.sv
dv/matrix3_inverse_tb.sv
